FILE: hdl/lmts_pkg.sv
package lmts_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    localparam logic [15:0] T_OAM    = 16'd160;
    localparam logic [15:0] T_XFER   = 16'd344;
    localparam logic [15:0] T_HBLANK = 16'd408;
    localparam logic [15:0] T_VLINE  = 16'd912;

    localparam logic [7:0] VBLANK_FIRST_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE         = 8'd153;

endpackage

FILE: hdl/lcd_mode_timing_sequencer_unit.sv
// Channel  | valid         | flow control  | payload
// ---------+---------------+---------------+------------------------------------------
// in       | i_in_valid    | o_in_stall    | i_tick_count
// out      | o_out_valid   | i_out_stall   | o_mode, o_scanline, o_vblank_irq, o_draw_line
// cfg      | i_cfg_valid   | o_cfg_ready   | i_display_enable
//
// One item per clock unless the output stalls; each item passes the input register, then the result register.
// The mode, phase and line update sits between the two registers and is combinational.
// Synchronous active-low reset clears all control state, mode, phase, line and last tick.
// A stalled output holds its result; the input stalls only when both registers are full.
// Configuration transfers are always taken (o_cfg_ready is held high).
module lcd_mode_timing_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_tick_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_mode,
    output logic [7:0]  o_scanline,
    output logic        o_vblank_irq,
    output logic        o_draw_line,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_display_enable
);

    logic                 r_enable;
    logic                 r_in_valid;
    logic [31:0]          r_in_tick;
    lmts_pkg::t_mode      r_mode,  n_mode;
    logic [15:0]          r_phase, n_phase;
    logic [7:0]           r_line,  n_line;
    logic [31:0]          r_last,  n_last;
    logic                 r_out_valid;
    lmts_pkg::t_mode      r_out_mode;
    logic [7:0]           r_out_line;
    logic                 r_out_irq, n_irq;
    logic                 r_out_draw, n_draw;
    logic                 adv;
    logic                 in_take;
    logic [31:0]          elapsed;
    logic [15:0]          phase_sum;
    logic [7:0]           line_inc;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign elapsed   = r_in_tick - r_last;
    assign phase_sum = r_phase + elapsed[15:0];
    assign line_inc  = r_line + 8'd1;

    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_line  = r_line;
        n_last  = r_last;
        n_irq   = 1'b0;
        n_draw  = 1'b0;
        if (r_enable) begin
            n_phase = phase_sum;
            n_last  = r_in_tick;
            case (r_mode)
                lmts_pkg::MODE_HBLANK: begin
                    if (phase_sum >= lmts_pkg::T_HBLANK) begin
                        n_line  = line_inc;
                        n_phase = phase_sum - lmts_pkg::T_HBLANK;
                        if (line_inc == lmts_pkg::VBLANK_FIRST_LINE) begin
                            n_mode = lmts_pkg::MODE_VBLANK;
                            n_irq  = 1'b1;
                        end else begin
                            n_mode = lmts_pkg::MODE_OAM;
                        end
                    end
                end
                lmts_pkg::MODE_VBLANK: begin
                    if (phase_sum >= lmts_pkg::T_VLINE) begin
                        n_phase = phase_sum - lmts_pkg::T_VLINE;
                        // wrap to the top of the frame after the last vblank line
                        if (line_inc > lmts_pkg::LAST_LINE) begin
                            n_line = 8'd0;
                            n_mode = lmts_pkg::MODE_OAM;
                        end else begin
                            n_line = line_inc;
                        end
                    end
                end
                lmts_pkg::MODE_OAM: begin
                    if (phase_sum >= lmts_pkg::T_OAM) begin
                        n_mode  = lmts_pkg::MODE_XFER;
                        n_phase = phase_sum - lmts_pkg::T_OAM;
                    end
                end
                lmts_pkg::MODE_XFER: begin
                    if (phase_sum >= lmts_pkg::T_XFER) begin
                        n_mode  = lmts_pkg::MODE_HBLANK;
                        n_phase = phase_sum - lmts_pkg::T_XFER;
                        n_draw  = 1'b1;
                    end
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= lmts_pkg::MODE_HBLANK;
            r_phase     <= 16'd0;
            r_line      <= 8'd0;
            r_last      <= 32'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_enable <= i_display_enable;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_phase     <= n_phase;
                r_line      <= n_line;
                r_last      <= n_last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_tick <= i_tick_count;
        end
        if (adv) begin
            r_out_mode <= n_mode;
            r_out_line <= n_line;
            r_out_irq  <= n_irq;
            r_out_draw <= n_draw;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode       = r_out_mode;
    assign o_scanline   = r_out_line;
    assign o_vblank_irq = r_out_irq;
    assign o_draw_line  = r_out_draw;

    a_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_vblank_irq && o_draw_line))
        else $error("vblank irq and draw line raised together");

    a_irq_enters_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_vblank_irq) |->
            (o_mode == lmts_pkg::MODE_VBLANK && o_scanline == lmts_pkg::VBLANK_FIRST_LINE))
        else $error("vblank irq without entry to vblank on first vblank line");

    a_draw_enters_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_draw_line) |-> o_mode == lmts_pkg::MODE_HBLANK)
        else $error("draw line without entry to hblank");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

endmodule
